/* rtl/i2cm_pkg.sv */
// ---------------------------------------------------------------------------
// i2cm_pkg
// shared word types and configuration bundle for the i2c register master
// ---------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 10;

	// command opcodes carried by each input word
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// one input word: a timing tick, optionally with a command
	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       sda_sample;
	} in_word_t;

	// one result word: line levels and status after the tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       byte_request;
		logic       transfer_done;
		logic       fail_status;
		logic       busy_res;
	} out_word_t;

	// timing settings from the configuration registers
	typedef struct packed {
		logic [7:0] start_stop_hold_ticks;
		logic [7:0] bit_phase_ticks;
		logic [9:0] ack_timeout_ticks;
	} cfg_t;

endpackage

/* rtl/i2cm_cfg_regs.sv */
// ---------------------------------------------------------------------------
// i2cm_cfg_regs
// timing configuration registers, written through a plain write port
// ---------------------------------------------------------------------------
module i2cm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data,
	output i2cm_pkg::cfg_t                cfg
);

	localparam logic [i2cm_pkg::CfgIdxW-1:0] IDX_HOLD    = 2'd0;
	localparam logic [i2cm_pkg::CfgIdxW-1:0] IDX_PHASE   = 2'd1;
	localparam logic [i2cm_pkg::CfgIdxW-1:0] IDX_TIMEOUT = 2'd2;

	i2cm_pkg::cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_stop_hold_ticks <= 8'd5;
			cfg_q.bit_phase_ticks       <= 8'd2;
			cfg_q.ack_timeout_ticks     <= 10'd250;
		end else if (cfg_we) begin
			unique case (cfg_index)
				IDX_HOLD:    cfg_q.start_stop_hold_ticks <= cfg_data[7:0];
				IDX_PHASE:   cfg_q.bit_phase_ticks       <= cfg_data[7:0];
				IDX_TIMEOUT: cfg_q.ack_timeout_ticks     <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/i2cm_engine.sv */
// ---------------------------------------------------------------------------
// i2cm_engine
// bus sequencer state and the per-tick next-state and result logic
// ---------------------------------------------------------------------------
module i2cm_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cm_pkg::cfg_t      cfg,
	input  logic                step,
	input  i2cm_pkg::in_word_t  item,
	output i2cm_pkg::out_word_t result
);

	// sequencer phases
	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_START_HIGH = 4'd1;
	localparam logic [3:0] PH_START_LOW  = 4'd2;
	localparam logic [3:0] PH_TX_LOW     = 4'd3;
	localparam logic [3:0] PH_TX_HIGH    = 4'd4;
	localparam logic [3:0] PH_ACK_LOW    = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH   = 4'd6;
	localparam logic [3:0] PH_LOAD       = 4'd7;
	localparam logic [3:0] PH_RX_LOW     = 4'd8;
	localparam logic [3:0] PH_RX_HIGH    = 4'd9;
	localparam logic [3:0] PH_MACK_LOW   = 4'd10;
	localparam logic [3:0] PH_MACK_HIGH  = 4'd11;
	localparam logic [3:0] PH_STOP_LOW   = 4'd12;
	localparam logic [3:0] PH_STOP_HIGH  = 4'd13;

	// byte currently on the bus
	localparam logic [1:0] SEG_ADDR_W = 2'd0;
	localparam logic [1:0] SEG_REG    = 2'd1;
	localparam logic [1:0] SEG_ADDR_R = 2'd2;
	localparam logic [1:0] SEG_DATA   = 2'd3;

	logic [3:0] phase_q, n_phase;
	logic [9:0] tick_q, n_tick;
	logic [3:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift;
	logic [7:0] left_q, n_left;
	logic [6:0] dev_q, n_dev;
	logic [7:0] reg_q, n_reg;
	logic       rd_q, n_rd;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic [1:0] seg_q, n_seg;
	logic       fail_q, n_fail;

	logic       ent;
	logic [3:0] tgt;
	logic [9:0] tick_inc;
	logic [7:0] dur;
	logic [3:0] bit_inc;
	logic [7:0] left_dec;
	logic       o_req, o_valid, o_done, o_fail;
	logic [7:0] o_rb;
	logic       released;

	assign tick_inc = tick_q + 10'd1;
	assign bit_inc  = bit_q + 4'd1;
	assign left_dec = left_q - 8'd1;
	assign dur = (phase_q == PH_START_HIGH || phase_q == PH_START_LOW ||
		phase_q == PH_STOP_LOW || phase_q == PH_STOP_HIGH) ?
		cfg.start_stop_hold_ticks : cfg.bit_phase_ticks;

	// next state for one tick
	always_comb begin
		n_phase = phase_q;
		n_tick  = tick_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_dev   = dev_q;
		n_reg   = reg_q;
		n_rd    = rd_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_seg   = seg_q;
		n_fail  = fail_q;
		ent     = 1'b0;
		tgt     = phase_q;
		o_req   = 1'b0;
		o_valid = 1'b0;
		o_rb    = 8'd0;
		o_done  = 1'b0;
		o_fail  = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.opcode == i2cm_pkg::OP_WRITE || item.opcode == i2cm_pkg::OP_READ) begin
				n_dev  = item.device_address;
				n_reg  = item.register_address;
				n_left = item.byte_count;
				n_rd   = (item.opcode == i2cm_pkg::OP_READ);
				n_seg  = SEG_ADDR_W;
				n_fail = 1'b0;
				ent    = 1'b1;
				tgt    = PH_START_HIGH;
			end
		end else if (phase_q == PH_ACK_HIGH) begin
			if (!item.sda_sample) begin
				// acknowledge seen: move on by segment
				ent = 1'b1;
				case (seg_q)
					SEG_ADDR_W: begin
						n_seg   = SEG_REG;
						n_shift = reg_q;
						n_bit   = 4'd0;
						tgt     = PH_TX_LOW;
					end
					SEG_REG: begin
						if (rd_q) begin
							n_seg = SEG_ADDR_R;
							tgt   = PH_START_HIGH;
						end else if (left_q == 8'd0) begin
							n_fail = 1'b0;
							tgt    = PH_STOP_LOW;
						end else begin
							n_seg = SEG_DATA;
							o_req = 1'b1;
							tgt   = PH_LOAD;
						end
					end
					SEG_ADDR_R: begin
						if (left_q == 8'd0) begin
							n_fail = 1'b0;
							tgt    = PH_STOP_LOW;
						end else begin
							n_bit   = 4'd0;
							n_shift = 8'd0;
							tgt     = PH_RX_LOW;
						end
					end
					default: begin
						n_left = left_dec;
						if (left_dec == 8'd0) begin
							n_fail = 1'b0;
							tgt    = PH_STOP_LOW;
						end else begin
							o_req = 1'b1;
							tgt   = PH_LOAD;
						end
					end
				endcase
			end else if (tick_q >= cfg.ack_timeout_ticks) begin
				n_fail = 1'b1;
				ent    = 1'b1;
				tgt    = PH_STOP_LOW;
			end else begin
				n_tick = tick_inc;
			end
		end else if (phase_q == PH_LOAD) begin
			n_shift = item.write_byte;
			n_bit   = 4'd0;
			ent     = 1'b1;
			tgt     = PH_TX_LOW;
		end else if (phase_q > PH_STOP_HIGH) begin
			ent = 1'b1;
			tgt = PH_IDLE;
		end else begin
			// timed phases: count ticks, act at the end of the phase
			n_tick = tick_inc;
			if (tick_inc >= {2'd0, dur}) begin
				ent = 1'b1;
				unique case (phase_q)
					PH_START_HIGH: tgt = PH_START_LOW;
					PH_START_LOW: begin
						n_shift = {dev_q, seg_q == SEG_ADDR_R};
						n_bit   = 4'd0;
						tgt     = PH_TX_LOW;
					end
					PH_TX_LOW: tgt = PH_TX_HIGH;
					PH_TX_HIGH: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_inc;
						tgt     = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
					end
					PH_ACK_LOW: tgt = PH_ACK_HIGH;
					PH_RX_LOW:  tgt = PH_RX_HIGH;
					PH_RX_HIGH: begin
						n_shift = {shift_q[6:0], item.sda_sample};
						n_bit   = bit_inc;
						if (bit_inc >= 4'd8) begin
							o_valid = 1'b1;
							o_rb    = {shift_q[6:0], item.sda_sample};
							tgt     = PH_MACK_LOW;
						end else begin
							tgt = PH_RX_LOW;
						end
					end
					PH_MACK_LOW: tgt = PH_MACK_HIGH;
					PH_MACK_HIGH: begin
						n_left = left_dec;
						if (left_dec == 8'd0) begin
							n_fail = 1'b0;
							tgt    = PH_STOP_LOW;
						end else begin
							n_bit   = 4'd0;
							n_shift = 8'd0;
							tgt     = PH_RX_LOW;
						end
					end
					PH_STOP_LOW: tgt = PH_STOP_HIGH;
					default: begin
						o_done = 1'b1;
						o_fail = fail_q;
						tgt    = PH_IDLE;
					end
				endcase
			end
		end

		// phase entry: restart the tick count and set the line levels
		if (ent) begin
			n_phase = tgt;
			n_tick  = 10'd0;
			case (tgt)
				PH_START_LOW: begin
					n_scl = 1'b1;
					n_sda = 1'b0;
				end
				PH_TX_LOW: begin
					n_scl = 1'b0;
					n_sda = n_shift[7];
				end
				PH_TX_HIGH, PH_MACK_HIGH: n_scl = 1'b1;
				PH_ACK_LOW, PH_LOAD, PH_RX_LOW: begin
					n_scl = 1'b0;
					n_sda = 1'b1;
				end
				PH_MACK_LOW: begin
					n_scl = 1'b0;
					n_sda = (n_left > 8'd1) ? 1'b0 : 1'b1;
				end
				PH_STOP_LOW: begin
					n_scl = 1'b0;
					n_sda = 1'b0;
				end
				default: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
			endcase
		end
	end

	// result word from the state after this tick
	assign released = (n_phase == PH_ACK_LOW || n_phase == PH_ACK_HIGH ||
		n_phase == PH_LOAD || n_phase == PH_RX_LOW || n_phase == PH_RX_HIGH);

	always_comb begin
		result.scl_level        = n_scl;
		result.sda_level        = released ? 1'b1 : n_sda;
		result.sda_drive_enable = ~released;
		result.read_byte        = o_rb;
		result.read_valid       = o_valid;
		result.byte_request     = o_req;
		result.transfer_done    = o_done;
		result.fail_status      = o_fail;
		result.busy_res         = (n_phase != PH_IDLE);
	end

	// state update when a word is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 10'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			left_q  <= 8'd0;
			dev_q   <= 7'd0;
			reg_q   <= 8'd0;
			rd_q    <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			seg_q   <= SEG_ADDR_W;
			fail_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			tick_q  <= n_tick;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			left_q  <= n_left;
			dev_q   <= n_dev;
			reg_q   <= n_reg;
			rd_q    <= n_rd;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			seg_q   <= n_seg;
			fail_q  <= n_fail;
		end
	end

endmodule

/* rtl/i2c_master_register_transfer_core.sv */
// ---------------------------------------------------------------------------
// i2c_master_register_transfer_core
// i2c master for device register reads and writes, one timing tick per word
// ---------------------------------------------------------------------------
//  channel | signals                         | direction | word
//  in      | in_valid, in_stall, in_word     | to core   | tick and command
//  out     | out_valid, out_stall, out_word  | from core | lines and status
//  cfg     | cfg_we, cfg_index, cfg_data     | to core   | timing register
//
//  one input word per cycle is sustained while out is not stalled; each word
//  yields one result word via the input register, then the result register
//  the sequencer state loop, updated on each committed word, sets the rate
//  reset clears pipeline and bus state (lines high, idle), loads default timing
//  a stall on out holds the result register and backs up into in_stall
// ---------------------------------------------------------------------------
module i2c_master_register_transfer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  i2cm_pkg::in_word_t            in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output i2cm_pkg::out_word_t           out_word,
	input  logic                          cfg_we,
	input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data
);

	i2cm_pkg::cfg_t      cfg;
	i2cm_pkg::in_word_t  word_s1;
	logic                valid_s1;
	i2cm_pkg::out_word_t result;
	i2cm_pkg::out_word_t out_word_q;
	logic                out_valid_q;
	logic                out_free;
	logic                step;
	logic                take;

	// handshake: stage 1 advances when the result register can load
	assign out_free = ~out_valid_q | ~out_stall;
	assign step     = valid_s1 & out_free;
	assign take     = ~valid_s1 | out_free;
	assign in_stall = ~take;

	i2cm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			word_s1 <= in_word;
		end
	end

	i2cm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (word_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
